FILE: rtl/npc_pkg.sv
// npc_pkg: shared types and constants of the nearest palette color block.
// Used by npc_dist_pipe and nearest_palette_color_top; depends on nothing.
package npc_pkg;

  // default palette depth and widths fixed by the word format
  localparam int DEF_PALETTE_DEPTH = 16;
  localparam int CNT_W     = 5;    // palette_count register
  localparam int IDX_W     = 4;    // entry_index and best_index fields
  localparam int CH_W      = 8;    // one color channel
  localparam int RGB_W     = 3 * CH_W;
  localparam int DIST_W    = 18;   // best_distance field
  localparam int CMP_W     = 9;    // holds any depth up to 256 for compares
  localparam int YUV_W     = 22;   // signed dY/dU/dV at scale 4096
  localparam int MAG_W     = 21;   // magnitude of dY/dU/dV
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 45;   // dY^2 + 4dU^2 + 4dV^2 plus rounding
  localparam int RND_SHIFT = 26;

  // word layout on the input and output streams
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // request kinds carried in in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // YUV coefficients, scaled by 4096
  localparam logic signed [YUV_W-1:0] C_YR = 22'sd1225;
  localparam logic signed [YUV_W-1:0] C_YG = 22'sd2404;
  localparam logic signed [YUV_W-1:0] C_YB = 22'sd467;
  localparam logic signed [YUV_W-1:0] C_UR = -22'sd692;
  localparam logic signed [YUV_W-1:0] C_UG = -22'sd1356;
  localparam logic signed [YUV_W-1:0] C_UB = 22'sd2048;
  localparam logic signed [YUV_W-1:0] C_VR = 22'sd2048;
  localparam logic signed [YUV_W-1:0] C_VG = -22'sd1716;
  localparam logic signed [YUV_W-1:0] C_VB = -22'sd332;

  // control tag that rides along the distance pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

endpackage

FILE: rtl/npc_dist_pipe.sv
// npc_dist_pipe: three-stage weighted YUV distance between a query color and
// one palette entry. Depends on npc_pkg for widths, coefficients and tag_t.
module npc_dist_pipe #(
  parameter int IW = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [npc_pkg::CH_W-1:0]    q_red,
  input  logic [npc_pkg::CH_W-1:0]    q_green,
  input  logic [npc_pkg::CH_W-1:0]    q_blue,
  input  logic [npc_pkg::RGB_W-1:0]   p_rgb,      // [7:0] red, [15:8] green, [23:16] blue
  input  npc_pkg::tag_t               tag_in,
  input  logic [IW-1:0]               idx_in,
  output npc_pkg::tag_t               tag_out,
  output logic [IW-1:0]               idx_out,
  output logic [npc_pkg::DIST_W-1:0]  dist_out
);

  localparam int YW = npc_pkg::YUV_W;
  localparam int MW = npc_pkg::MAG_W;
  localparam int SW = npc_pkg::SQ_W;
  localparam int UW = npc_pkg::SUM_W;

  npc_pkg::tag_t tag_b_r, tag_c_r, tag_d_r;
  logic [IW-1:0] idx_b_r, idx_c_r, idx_d_r;

  // stage B: channel differences and YUV conversion
  logic signed [YW-1:0] dr, dg, db;
  logic signed [YW-1:0] dy_nxt, du_nxt, dv_nxt;
  logic signed [YW-1:0] dy_r, du_r, dv_r;

  always_comb begin
    dr = YW'($signed({1'b0, q_red}))   - YW'($signed({1'b0, p_rgb[7:0]}));
    dg = YW'($signed({1'b0, q_green})) - YW'($signed({1'b0, p_rgb[15:8]}));
    db = YW'($signed({1'b0, q_blue}))  - YW'($signed({1'b0, p_rgb[23:16]}));
    dy_nxt = npc_pkg::C_YR * dr + npc_pkg::C_YG * dg + npc_pkg::C_YB * db;
    du_nxt = npc_pkg::C_UR * dr + npc_pkg::C_UG * dg + npc_pkg::C_UB * db;
    dv_nxt = npc_pkg::C_VR * dr + npc_pkg::C_VG * dg + npc_pkg::C_VB * db;
  end

  always_ff @(posedge clk) begin
    dy_r <= dy_nxt;
    du_r <= du_nxt;
    dv_r <= dv_nxt;
  end

  // stage C: squares of the magnitudes
  logic [MW-1:0] my, mu, mv;
  logic [SW-1:0] sqy_r, squ_r, sqv_r;

  always_comb begin
    my = dy_r[YW-1] ? MW'(-dy_r) : MW'(dy_r);
    mu = du_r[YW-1] ? MW'(-du_r) : MW'(du_r);
    mv = dv_r[YW-1] ? MW'(-dv_r) : MW'(dv_r);
  end

  always_ff @(posedge clk) begin
    sqy_r <= SW'(my) * SW'(my);
    squ_r <= SW'(mu) * SW'(mu);
    sqv_r <= SW'(mv) * SW'(mv);
  end

  // stage D: weighted sum, round half up, scale down
  logic [UW-1:0] sum;
  logic [npc_pkg::DIST_W-1:0] dist_r;

  always_comb begin
    sum = UW'(sqy_r) + (UW'(squ_r) << 2) + (UW'(sqv_r) << 2)
        + (UW'(1) << (npc_pkg::RND_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    dist_r <= sum[npc_pkg::RND_SHIFT +: npc_pkg::DIST_W];
  end

  // tag and index follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
      tag_c_r <= '0;
      tag_d_r <= '0;
    end else begin
      tag_b_r <= tag_in;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_c_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_b_r <= idx_in;
    idx_c_r <= idx_b_r;
    idx_d_r <= idx_c_r;
  end

  assign tag_out  = tag_d_r;
  assign idx_out  = idx_d_r;
  assign dist_out = dist_r;

endmodule

FILE: rtl/nearest_palette_color_top.sv
// nearest_palette_color_top: palette memory, scan sequencer and best-entry tracker.
// Depends on npc_pkg and instantiates npc_dist_pipe.
//
// A write word (tuser 0) stores one RGB palette entry; writes to an entry at or
// above PALETTE_DEPTH are dropped. A query word (tuser 1) scans
// entries 0 .. palette_count-1 (a count of zero searches entry 0, a count above
// the depth searches the whole palette), reading one entry per cycle from the
// palette memory into a shared distance pipeline. Each searched entry passes
// through one read at the single read port, three distance stages and the
// best-entry update; the output register is then loaded once it is free, and
// the input stays stalled until that load. Ties go to the lowest index.
// The result sits in an output register, so new writes are accepted
// while it waits. Entries that were never written hold arbitrary data. The user
// must see that palette_count is written only while the block is idle; the block
// itself does not enforce it.
module nearest_palette_color_top #(
  parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [npc_pkg::IN_TDATA_W-1:0]    in_tdata,  // entry_index, red, green, blue, pad
  input  logic                              in_tuser,  // req_type
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [npc_pkg::OUT_TDATA_W-1:0]   out_tdata, // best_index, best_distance, pad
  // configuration: palette_count
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npc_pkg::CNT_W-1:0]         cfg_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = npc_pkg::CMP_W;
  localparam int DW = npc_pkg::DIST_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  // input word fields
  logic [npc_pkg::IDX_W-1:0] in_entry_index;
  logic [npc_pkg::CH_W-1:0]  in_red, in_green, in_blue;
  logic                      in_acc;

  assign in_entry_index = in_tdata[3:0];
  assign in_red         = in_tdata[11:4];
  assign in_green       = in_tdata[19:12];
  assign in_blue        = in_tdata[27:20];
  assign in_acc         = in_tvalid && in_tready;

  // configuration register
  logic [npc_pkg::CNT_W-1:0] count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= npc_pkg::CNT_W'(1);
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // last index searched, with zero and over-depth counts clamped
  logic [CW-1:0] cnt_ext;
  logic [AW-1:0] last_idx;

  always_comb begin
    cnt_ext = CW'(count_r);
    if (cnt_ext == '0) begin
      last_idx = '0;
    end else if (cnt_ext > CW'(PALETTE_DEPTH)) begin
      last_idx = AW'(PALETTE_DEPTH - 1);
    end else begin
      last_idx = AW'(cnt_ext - CW'(1));
    end
  end

  // sequencer state
  state_t        state_r, state_nxt;
  logic [AW-1:0] issue_r, issue_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;

  // query color, held for the whole scan
  logic [npc_pkg::CH_W-1:0] q_red_r, q_green_r, q_blue_r;

  // palette memory, one write port and one registered read port; the sequencer only
  // writes in idle, and only reads issued in ST_ISSUE are tagged valid for the scan
  logic [npc_pkg::RGB_W-1:0] pal_mem [0:PALETTE_DEPTH-1];
  logic [npc_pkg::RGB_W-1:0] rd_data_r;
  logic                      wr_en;

  assign wr_en = in_acc && (in_tuser == npc_pkg::REQ_WRITE)
              && (CW'(in_entry_index) < CW'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[AW'(in_entry_index)] <= {in_blue, in_green, in_red};
    end
    rd_data_r <= pal_mem[issue_r];
  end

  // read-stage tag and index
  npc_pkg::tag_t tag1_r;
  logic [AW-1:0] idx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r.vld  <= (state_r == ST_ISSUE);
      tag1_r.last <= (state_r == ST_ISSUE) && (issue_r == last_r);
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= issue_r;
  end

  // distance pipeline
  npc_pkg::tag_t tag_d;
  logic [AW-1:0] idx_d;
  logic [DW-1:0] dist_d;

  npc_dist_pipe #(
    .IW (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_red    (q_red_r),
    .q_green  (q_green_r),
    .q_blue   (q_blue_r),
    .p_rgb    (rd_data_r),
    .tag_in   (tag1_r),
    .idx_in   (idx1_r),
    .tag_out  (tag_d),
    .idx_out  (idx_d),
    .dist_out (dist_d)
  );

  // best-entry tracker: entry 0 always seeds, strict less-than keeps lowest index
  logic [AW-1:0] best_idx_r;
  logic [DW-1:0] best_dist_r;

  always_ff @(posedge clk) begin
    if (tag_d.vld && ((idx_d == '0) || (dist_d < best_dist_r))) begin
      best_idx_r  <= idx_d;
      best_dist_r <= dist_d;
    end
  end

  // sequencer next state
  logic out_load;

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == npc_pkg::REQ_QUERY)) begin
          issue_nxt = '0;
          last_nxt  = last_idx;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          issue_nxt = issue_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (tag_d.vld && tag_d.last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // query color capture
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == npc_pkg::REQ_QUERY)) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  // output register
  logic [npc_pkg::IDX_W-1:0] out_idx_r;
  logic [DW-1:0]             out_dist_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= npc_pkg::IDX_W'(best_idx_r);
      out_dist_r <= best_dist_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dist_r, out_idx_r};

  // a new word is only taken with the distance pipeline empty
  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!tag1_r.vld && !tag_d.vld))
    else $error("input word accepted while the scan pipeline is busy");

  // a waiting result is never overwritten
  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && !out_tready) |=> (state_r == ST_HOLD))
    else $error("result register loaded while still occupied");

  // pipeline results only arrive during a scan
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_d.vld |-> (state_r == ST_ISSUE || state_r == ST_DRAIN))
    else $error("distance result outside a scan");

  // the issue counter never passes the last searched entry
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (issue_r <= last_r))
    else $error("issue counter passed the last entry");

  // the last entry leaves the pipeline after the read stage and the three distance stages
  a_last_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE && issue_r == last_r) |-> ##4 (tag_d.vld && tag_d.last))
    else $error("last entry did not leave the pipeline on time");

endmodule
